FILE: design/display_bus_tap_frame_decoder_assert.svh
// Assertion macros for the display bus tap frame decoder checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef DISPLAY_BUS_TAP_FRAME_DECODER_ASSERT_SVH
`define DISPLAY_BUS_TAP_FRAME_DECODER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define DBTFD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, implies another one on the next clock edge.
`define DBTFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dbtfd_pkg.sv
// Shared types, constants and helper functions of the display bus tap frame decoder.
// No dependencies; imported by the top level, front end, command queue and back end.
package dbtfd_pkg;

    localparam int BUFFER_DEPTH_DEF = 30;
    localparam int FRAME_MIN        = 14;
    localparam int CMDQ_DEPTH       = 2;
    localparam logic [15:0] TIMEOUT_RESET = 16'd20;

    // Digit positions inside a frame.
    localparam logic [3:0] DIG_SELECT     = 4'd0;
    localparam logic [3:0] DIG_TOTAL_LAST = 4'd7;
    localparam logic [3:0] DIG_RUN        = 4'd8;

    // Raw nibble codes tested by the select flags, and the limit for a decimal digit.
    localparam logic [3:0] NIB_SEL_L   = 4'd10;
    localparam logic [3:0] NIB_SEL_P   = 4'd12;
    localparam logic [3:0] DIGIT_LIMIT = 4'd10;

    typedef enum logic [1:0] {
        OP_BIT   = 2'd0,
        OP_LATCH = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic {
        CMD_LATCH = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } cmd_t;

    typedef struct packed {
        logic [19:0] unit_price;
        logic [23:0] total_price;
        logic [23:0] volume;
        logic        running;
        logic        sel_p;
        logic        sel_l;
    } frame_t;

    // A nibble of ten or more is read as the digit zero.
    function automatic logic [3:0] digit_of(input logic [3:0] nib);
        return (nib >= DIGIT_LIMIT) ? 4'd0 : nib;
    endfunction

    function automatic logic [23:0] mul10(input logic [23:0] x);
        return {x[20:0], 3'b000} + {x[22:0], 1'b0};
    endfunction

endpackage

FILE: design/display_bus_tap_frame_decoder.sv
// Display bus tap frame decoder. Each request is one bus event: a bit clock edge is
// finished in the front end; latch and tick events go through a two-entry command
// queue to the back end. A tick that closes a frame whose entry count, modulo the store
// depth, is at least fourteen makes the back end read entries 0 to 13 from its ring
// store, one a cycle, before the result is offered; further requests are taken until
// the queue fills.
// Store entries carry no reset; only entries written since reset are ever decoded.
// Depends on dbtfd_pkg, dbtfd_front, dbtfd_cmdq and dbtfd_back.
module display_bus_tap_frame_decoder
    import dbtfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic        line_a_bit,
    input  logic        line_b_bit,
    output logic        empty,
    input  logic        pop,
    output logic [19:0] frame_unit_price,
    output logic [23:0] frame_total_price,
    output logic [23:0] frame_volume,
    output logic        pump_running,
    output logic        select_p_flag,
    output logic        select_l_flag,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic   q_full, q_empty, q_push, q_pop, out_valid;
    cmd_t   push_cmd, head_cmd;
    frame_t out_frame;

    dbtfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .line_a_bit (line_a_bit),
        .line_b_bit (line_b_bit),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    dbtfd_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (push_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (head_cmd),
        .q_empty (q_empty)
    );

    dbtfd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_empty     (q_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_frame   (out_frame)
    );

    assign empty             = !out_valid;
    assign frame_unit_price  = out_frame.unit_price;
    assign frame_total_price = out_frame.total_price;
    assign frame_volume      = out_frame.volume;
    assign pump_running      = out_frame.running;
    assign select_p_flag     = out_frame.sel_p;
    assign select_l_flag     = out_frame.sel_l;

endmodule

FILE: design/dbtfd_front.sv
// Front end of the frame decoder: accepts bus events and shifts the data lines.
// Latch and tick events are passed on as commands. Depends on dbtfd_pkg.
module dbtfd_front
    import dbtfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] operation,
    input  logic       line_a_bit,
    input  logic       line_b_bit,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic [7:0] shift_a_reg, shift_a_next;
    logic [7:0] shift_b_reg, shift_b_next;
    logic       accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        shift_a_next = shift_a_reg;
        shift_b_next = shift_b_reg;
        q_push       = 1'b0;
        q_cmd.kind   = CMD_LATCH;
        q_cmd.byte_a = shift_a_reg;
        q_cmd.byte_b = shift_b_reg;
        unique case (op_t'(operation))
            OP_BIT:
            begin
                shift_a_next = {shift_a_reg[6:0], line_a_bit};
                shift_b_next = {shift_b_reg[6:0], line_b_bit};
            end
            OP_LATCH:
            begin
                q_push = accept;
            end
            OP_TICK:
            begin
                q_push     = accept;
                q_cmd.kind = CMD_TICK;
            end
            default:
            begin
                // The unused operation code is dropped here.
                q_push = 1'b0;
            end
        endcase
        if (!accept)
        begin
            shift_a_next = shift_a_reg;
            shift_b_next = shift_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_a_reg <= 8'd0;
            shift_b_reg <= 8'd0;
        end
        else
        begin
            shift_a_reg <= shift_a_next;
            shift_b_reg <= shift_b_next;
        end
    end

endmodule

FILE: design/dbtfd_cmdq.sv
// Short command queue between the front end and the back end.
// Depends on dbtfd_pkg for the command type and the queue depth.
module dbtfd_cmdq
    import dbtfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic q_full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic q_empty
);

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          slot_reg [CMDQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign q_full  = (count_reg == CW'(CMDQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_cmd  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/dbtfd_back.sv
// Back end of the frame decoder: ring store, frame timer and digit decoder.
// Holds the timeout register and the one-entry result register. Depends on dbtfd_pkg.
module dbtfd_back
    import dbtfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        q_empty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    input  logic        pop,
    output logic        out_valid,
    output frame_t      out_frame
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [15:0]   timeout_ticks_reg;
    logic [15:0]   count_reg, count_next;
    logic          armed_reg, armed_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [3:0]    step_reg, step_next;
    logic [3:0]    dig_idx;
    frame_t        acc_reg, acc_next;
    frame_t        out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic [15:0]   mem [BUFFER_DEPTH];
    logic [15:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [3:0]    nib_a, nib_b, dig_a, dig_b;

    assign out_valid = out_valid_reg;
    assign out_frame = out_reg;

    assign nib_a   = rd_data_reg[15:12];
    assign nib_b   = rd_data_reg[7:4];
    assign dig_a   = digit_of(nib_a);
    assign dig_b   = digit_of(nib_b);
    assign dig_idx = step_reg - 4'd1;
    assign rd_addr = (step_reg < 4'(FRAME_MIN)) ? AW'(step_reg) : '0;

    assign q_pop  = (state_reg == ST_IDLE) && !q_empty;
    assign mem_we = q_pop && (q_cmd.kind == CMD_LATCH);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        armed_next     = armed_reg;
        wr_idx_next    = wr_idx_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    unique case (q_cmd.kind)
                        CMD_LATCH:
                        begin
                            wr_idx_next = (wr_idx_reg == AW'(BUFFER_DEPTH - 1)) ?
                                          '0 : wr_idx_reg + 1'b1;
                            count_next  = timeout_ticks_reg;
                            armed_next  = 1'b1;
                        end
                        CMD_TICK:
                        begin
                            if (armed_reg)
                            begin
                                if (count_reg > 16'd1)
                                begin
                                    count_next = count_reg - 16'd1;
                                end
                                else
                                begin
                                    // The frame closes; decode it only if it is long enough.
                                    count_next  = 16'd0;
                                    armed_next  = 1'b0;
                                    wr_idx_next = '0;
                                    if (wr_idx_reg >= AW'(FRAME_MIN))
                                    begin
                                        state_next = ST_READ;
                                        step_next  = 4'd0;
                                        acc_next   = '0;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Entry step-1 arrives from the store while entry step is requested.
                if (step_reg != 4'd0)
                begin
                    priority if (dig_idx == DIG_SELECT)
                    begin
                        acc_next.sel_l = (nib_a == NIB_SEL_L);
                        acc_next.sel_p = (nib_b == NIB_SEL_P);
                    end
                    else if (dig_idx <= DIG_TOTAL_LAST)
                    begin
                        acc_next.total_price = mul10(acc_reg.total_price) + 24'(dig_a);
                        acc_next.volume      = mul10(acc_reg.volume) + 24'(dig_b);
                    end
                    else if (dig_idx == DIG_RUN)
                    begin
                        acc_next.running    = (dig_b == 4'd1);
                        acc_next.unit_price = 20'(dig_a);
                    end
                    else
                    begin
                        acc_next.unit_price =
                            20'(mul10(24'(acc_reg.unit_price)) + 24'(dig_a));
                    end
                end
                if (step_reg == 4'(FRAME_MIN))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx_reg] <= {q_cmd.byte_a, q_cmd.byte_b};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= 16'd0;
            armed_reg     <= 1'b0;
            wr_idx_reg    <= '0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            armed_reg     <= armed_next;
            wr_idx_reg    <= wr_idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/dbtfd_checker.sv
// Port-level checker for the display bus tap frame decoder, bound to the top level.
// Depends on display_bus_tap_frame_decoder_assert.svh.
`include "display_bus_tap_frame_decoder_assert.svh"

module dbtfd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [1:0]  operation,
    input logic        line_a_bit,
    input logic        line_b_bit,
    input logic        empty,
    input logic        pop,
    input logic [19:0] frame_unit_price,
    input logic [23:0] frame_total_price,
    input logic [23:0] frame_volume,
    input logic        pump_running,
    input logic        select_p_flag,
    input logic        select_l_flag,
    input logic        cfg_wr_en,
    input logic [15:0] cfg_wr_data
);

    // Out-of-range nibbles are read as zero, so every decoded value stays decimal.
    `DBTFD_ASSERT_ALWAYS(a_unit_range, empty || (frame_unit_price <= 20'd999999), "unit price above six digits")
    `DBTFD_ASSERT_ALWAYS(a_total_range, empty || (frame_total_price <= 24'd9999999), "total price above seven digits")
    `DBTFD_ASSERT_ALWAYS(a_volume_range, empty || (frame_volume <= 24'd9999999), "volume above seven digits")
    `DBTFD_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(frame_unit_price) && $stable(frame_total_price) && $stable(frame_volume) && $stable(pump_running), "waiting result changed")

endmodule

bind display_bus_tap_frame_decoder dbtfd_checker u_checker (.*);
